// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the RTL, clocked on clk_i and muted in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication from a trigger to a consequence in the following cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg
// Codes, default sizes and shared types of the number table matcher.
// ----------------------------------------------------------------------------
package nts_pkg;

  localparam int unsigned NTS_ENTRIES      = 8;
  localparam int unsigned NTS_NUMBER_BYTES = 24;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_IN_W = 8;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MATCH_W  = 3;

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_ALL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;

  // Per-cell commands for one accepted transfer.
  typedef struct packed {
    logic clear;       // drop the entry and its match state
    logic mark_valid;  // entry becomes valid (write stream start)
    logic store;       // store the character at the write position
    logic qclear;      // query start: reset match vector and found flag
    logic qstep;       // advance the match vector by the character
  } cell_ctl_t;

  // Lowest-hit selection rippled along the cell row.
  typedef struct packed {
    logic               hit;
    logic [MATCH_W-1:0] idx;
  } sel_t;

endpackage

// ===== rtl/nts_cell.sv =====
// ----------------------------------------------------------------------------
// nts_cell
// One table entry: stored characters, length, valid bit and shift-and state.
// ----------------------------------------------------------------------------
module nts_cell import nts_pkg::*; #(
  parameter int unsigned SLOT    = NTS_NUMBER_BYTES - 1,
  parameter int unsigned POS_W   = $clog2(SLOT + 1),
  parameter int unsigned CELL_ID = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [CHAR_W-1:0] ch_i,
  input  logic [POS_W-1:0]  pos_i,
  input  sel_t              sel_i,
  output sel_t              sel_o,
  output logic              valid_o
);

  logic [CHAR_W-1:0] chars_q [SLOT];
  logic [SLOT-1:0]   pm_q, pm_d, eq_vec, pm_base;
  logic [POS_W-1:0]  len_q, len_d;
  logic              valid_q, valid_d;
  logic              found_q, found_d;
  logic              tail_hit;
  logic              my_hit;

  for (genvar j = 0; j < SLOT; j++) begin : g_char
    always_ff @(posedge clk_i) begin
      if (ctl_i.store && pos_i == POS_W'(j)) begin
        chars_q[j] <= ch_i;
      end
    end
    assign eq_vec[j] = (chars_q[j] == ch_i) && (POS_W'(j) < len_q);
  end

  always_comb begin
    pm_base  = ctl_i.qclear ? '0 : pm_q;
    pm_d     = pm_base;
    found_d  = ctl_i.qclear ? 1'b0 : found_q;
    len_d    = len_q;
    valid_d  = valid_q;
    tail_hit = 1'b0;
    if (ctl_i.qstep) begin
      pm_d = SLOT'({pm_base, 1'b1}) & eq_vec;
      for (int unsigned j = 0; j < SLOT; j++) begin
        if (len_q == POS_W'(j + 1) && pm_d[j]) begin
          tail_hit = 1'b1;
        end
      end
      found_d = found_d | tail_hit;
    end
    if (ctl_i.clear) begin
      pm_d    = '0;
      found_d = 1'b0;
      len_d   = '0;
      valid_d = ctl_i.mark_valid;
    end
    if (ctl_i.store) begin
      len_d = pos_i + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q    <= '0;
      found_q <= 1'b0;
      len_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pm_q    <= pm_d;
      found_q <= found_d;
      len_q   <= len_d;
      valid_q <= valid_d;
    end
  end

  // An empty valid entry matches any non-empty query.
  assign my_hit  = valid_q && (found_d || len_q == '0);
  assign valid_o = valid_q;

  always_comb begin
    sel_o = sel_i;
    if (!sel_i.hit && my_hit) begin
      sel_o.hit = 1'b1;
      sel_o.idx = MATCH_W'(CELL_ID);
    end
  end

endmodule

// ===== rtl/number_table_substring_matcher.sv =====
// ----------------------------------------------------------------------------
// number_table_substring_matcher
// Table of number strings with a streamed substring query.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle. Each table entry is a cell
// that compares the incoming character against all its stored characters and
// advances its shift-and vector in the same cycle, so the time a query character
// or write character takes does not grow with table size. Deletes and the
// final transfer of a write or query stream load one result into the output
// register, which shows it from the next cycle; while a result sits there
// untaken the input stalls. There is no clearing pass after reset.
`include "assert_macros.svh"

module number_table_substring_matcher import nts_pkg::*; #(
  parameter int unsigned ENTRIES      = NTS_ENTRIES,
  parameter int unsigned NUMBER_BYTES = NTS_NUMBER_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [IDX_IN_W-1:0] entry_index_i,
  input  logic [CHAR_W-1:0]   ch_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [MATCH_W-1:0]  match_index_o
);

  localparam int unsigned SLOT  = NUMBER_BYTES - 1;
  localparam int unsigned POS_W = $clog2(SLOT + 1);
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic                stream_open_q, stream_open_d;
  logic                kind_query_q, kind_query_d;
  logic [IDX_W-1:0]    wr_entry_q, wr_entry_d;
  logic                wr_err_q, wr_err_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    store_pos;
  logic                ended_q, ended_d;
  logic                nonempty_q, nonempty_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [MATCH_W-1:0]  match_q, match_d;

  logic             in_fire, is_stream, is_query, start, idx_ok, store_ok, step_ok;
  logic             res_load, del_all_fire, res_fail;
  logic [IDX_W-1:0] idx_sel;
  cell_ctl_t        ctl [ENTRIES];
  sel_t             chain [ENTRIES+1];
  logic [ENTRIES-1:0] valid_vec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_query   = (command_i == CMD_QUERY);
  assign is_stream  = (command_i == CMD_WRITE) || is_query;
  assign start      = !stream_open_q || (kind_query_q != is_query);
  assign idx_ok     = entry_index_i < IDX_IN_W'(ENTRIES);
  assign idx_sel    = entry_index_i[IDX_W-1:0];
  assign res_load   = in_fire && (!is_stream || last_i);

  // Stream control; a new stream restarts position and end tracking.
  always_comb begin
    stream_open_d = stream_open_q;
    kind_query_d  = kind_query_q;
    wr_entry_d    = wr_entry_q;
    wr_err_d      = wr_err_q;
    pos_d         = pos_q;
    store_pos     = '0;
    ended_d       = ended_q;
    nonempty_d    = nonempty_q;
    store_ok      = 1'b0;
    step_ok       = 1'b0;
    if (in_fire) begin
      if (!is_stream) begin
        stream_open_d = 1'b0;
      end else begin
        if (start) begin
          stream_open_d = 1'b1;
          kind_query_d  = is_query;
          pos_d         = '0;
          ended_d       = 1'b0;
          nonempty_d    = 1'b0;
          if (!is_query) begin
            wr_err_d   = !idx_ok;
            wr_entry_d = idx_ok ? idx_sel : '0;
          end
        end
        if (!ended_d) begin
          if (ch_i == '0) begin
            ended_d = 1'b1;
          end else if (!is_query) begin
            if (!wr_err_d && pos_d < POS_W'(SLOT)) begin
              store_ok  = 1'b1;
              store_pos = pos_d;
              pos_d     = pos_d + POS_W'(1);
            end
          end else begin
            nonempty_d = 1'b1;
            step_ok    = 1'b1;
          end
        end
        if (last_i) begin
          stream_open_d = 1'b0;
        end
      end
    end
  end

  for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
    always_comb begin
      ctl[e] = '0;
      if (in_fire) begin
        unique case (command_i)
          CMD_DELETE: begin
            ctl[e].clear = idx_ok && (idx_sel == IDX_W'(e));
          end
          CMD_DEL_ALL: begin
            ctl[e].clear = 1'b1;
          end
          CMD_WRITE: begin
            ctl[e].clear      = start && idx_ok && (idx_sel == IDX_W'(e));
            ctl[e].mark_valid = ctl[e].clear;
            ctl[e].store      = store_ok && (wr_entry_d == IDX_W'(e));
          end
          CMD_QUERY: begin
            ctl[e].qclear = start;
            ctl[e].qstep  = step_ok;
          end
          default: begin
            ctl[e] = '0;
          end
        endcase
      end
    end

    nts_cell #(
      .SLOT    (SLOT),
      .POS_W   (POS_W),
      .CELL_ID (e)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[e]),
      .ch_i    (ch_i),
      .pos_i   (store_pos),
      .sel_i   (chain[e]),
      .sel_o   (chain[e+1]),
      .valid_o (valid_vec[e])
    );
  end

  assign chain[0] = '0;

  // Result register; it loads on deletes and on the last transfer of a stream.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    match_d     = match_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      match_d     = '0;
      priority if (command_i == CMD_DELETE) begin
        status_d = idx_ok ? ST_OK : ST_RANGE;
      end else if (command_i == CMD_DEL_ALL) begin
        status_d = ST_OK;
      end else if (command_i == CMD_WRITE) begin
        status_d = wr_err_d ? ST_RANGE : ST_OK;
      end else if (nonempty_d && chain[ENTRIES].hit) begin
        status_d = ST_OK;
        match_d  = chain[ENTRIES].idx;
      end else begin
        status_d = ST_NO_MATCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_open_q <= 1'b0;
      kind_query_q  <= 1'b0;
      wr_entry_q    <= '0;
      wr_err_q      <= 1'b0;
      pos_q         <= '0;
      ended_q       <= 1'b0;
      nonempty_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      stream_open_q <= stream_open_d;
      kind_query_q  <= kind_query_d;
      wr_entry_q    <= wr_entry_d;
      wr_err_q      <= wr_err_d;
      pos_q         <= pos_d;
      ended_q       <= ended_d;
      nonempty_q    <= nonempty_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    match_q  <= match_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign match_index_o = match_q;

  assign del_all_fire = in_fire && (command_i == CMD_DEL_ALL);
  assign res_fail     = out_valid_q && (status_q != ST_OK);

  `ASSERT_NEXT(a_del_all_clears, del_all_fire, valid_vec == '0, "entry valid after delete-all")
  `ASSERT_CLK(a_pos_bound, pos_q <= POS_W'(SLOT), "write position beyond the entry slot")
  `ASSERT_CLK(a_idx_only_on_ok, !res_fail || match_q == '0, "match index on a failed result")
  `ASSERT_NEXT(a_result_loaded, res_load, out_valid_o, "closing transfer gave no result")

endmodule
